[hw/rtl/pal_pkg.sv]
package pal_pkg;

   localparam int MAX_POINTS_DEF  = 1024;
   localparam int COORD_WIDTH_DEF = 32;

   localparam int PC_W     = 11;
   localparam int ARC_W    = 31;
   localparam int FIELD_W  = 32;
   localparam int HEAD_W   = 16;
   localparam int IDX_W    = 10;
   localparam int CSR_IDX_W = 2;
   localparam int REQ_DATA_W = 144;
   localparam int RSP_DATA_W = 80;

   // CORDIC working width: normalized vectors stay below 2^42 times the gain
   localparam int CORDIC_W  = 56;
   localparam int ANG_W     = 26;
   localparam int ROT_STEPS = 20;
   localparam int CNT_W     = 6;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_POINT_COUNT  = 2'd0,
      CSR_CLOSED_TRACK = 2'd1,
      CSR_TOTAL_LENGTH = 2'd2,
      CSR_UNUSED       = 2'd3
   } pal_csr_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_MOD, ST_FIX, ST_SRCH, ST_SRCHU, ST_RDJ, ST_SETUP,
      ST_DIV, ST_MUL, ST_PRE, ST_NORM, ST_ROT, ST_OUT
   } pal_state_type;

   typedef enum logic [3:0] {
      OP_NONE, OP_WRITE, OP_LOAD, OP_MOD_STEP, OP_MOD_FIX, OP_SRCH_ISSUE,
      OP_SRCH_UPD, OP_RD_I, OP_RD_J, OP_SETUP, OP_DIV_STEP, OP_MUL_STEP,
      OP_PRE, OP_NORM_STEP, OP_ROT_STEP, OP_OUT
   } pal_op_type;

   typedef struct packed {
      pal_op_type op;
   } pal_cmd_type;

   typedef struct packed {
      logic mod_needed;
      logic srch_more;
      logic step_last;
      logic t_direct;
      logic norm_done;
      logic out_free;
   } pal_status_type;

   // atan(2^-k) in units of pi/2^23
   function automatic logic [ANG_W-1:0] atan_step(input logic [CNT_W-1:0] k);
      logic [ANG_W-1:0] v;
      unique case (k)
         6'd0:  v = 26'd2097152;
         6'd1:  v = 26'd1238021;
         6'd2:  v = 26'd654136;
         6'd3:  v = 26'd332050;
         6'd4:  v = 26'd166670;
         6'd5:  v = 26'd83415;
         6'd6:  v = 26'd41718;
         6'd7:  v = 26'd20860;
         6'd8:  v = 26'd10430;
         6'd9:  v = 26'd5215;
         6'd10: v = 26'd2608;
         6'd11: v = 26'd1304;
         6'd12: v = 26'd652;
         6'd13: v = 26'd326;
         6'd14: v = 26'd163;
         6'd15: v = 26'd81;
         6'd16: v = 26'd41;
         6'd17: v = 26'd20;
         6'd18: v = 26'd10;
         6'd19: v = 26'd5;
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage

[hw/rtl/pal_ctrl.sv]
module pal_ctrl
   import pal_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_fire,
   input  logic           req_query,
   input  pal_status_type status,
   output pal_cmd_type    cmd,
   output logic           req_ready
);

   pal_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire && req_query) begin
               state_in = status.mod_needed ? ST_MOD : ST_FIX;
            end
         end
         ST_MOD:   if (status.step_last) state_in = ST_FIX;
         ST_FIX:   state_in = ST_SRCH;
         ST_SRCH:  state_in = status.srch_more ? ST_SRCHU : ST_RDJ;
         ST_SRCHU: state_in = ST_SRCH;
         ST_RDJ:   state_in = ST_SETUP;
         ST_SETUP: state_in = status.t_direct ? ST_MUL : ST_DIV;
         ST_DIV:   if (status.step_last) state_in = ST_MUL;
         ST_MUL:   if (status.step_last) state_in = ST_PRE;
         ST_PRE:   state_in = ST_NORM;
         ST_NORM:  if (status.norm_done) state_in = ST_ROT;
         ST_ROT:   if (status.step_last) state_in = ST_OUT;
         ST_OUT:   if (status.out_free) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd.op    = OP_NONE;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_fire) cmd.op = req_query ? OP_LOAD : OP_WRITE;
         end
         ST_MOD:   cmd.op = OP_MOD_STEP;
         ST_FIX:   cmd.op = OP_MOD_FIX;
         ST_SRCH:  cmd.op = status.srch_more ? OP_SRCH_ISSUE : OP_RD_I;
         ST_SRCHU: cmd.op = OP_SRCH_UPD;
         ST_RDJ:   cmd.op = OP_RD_J;
         ST_SETUP: cmd.op = OP_SETUP;
         ST_DIV:   cmd.op = OP_DIV_STEP;
         ST_MUL:   cmd.op = OP_MUL_STEP;
         ST_PRE:   cmd.op = OP_PRE;
         ST_NORM:  cmd.op = status.norm_done ? OP_NONE : OP_NORM_STEP;
         ST_ROT:   cmd.op = OP_ROT_STEP;
         ST_OUT:   cmd.op = status.out_free ? OP_OUT : OP_NONE;
         default:  cmd.op = OP_NONE;
      endcase
   end

endmodule

[hw/rtl/pal_dp.sv]
module pal_dp
   import pal_pkg::*;
#(
   parameter int MAX_POINTS  = MAX_POINTS_DEF,
   parameter int COORD_WIDTH = COORD_WIDTH_DEF
)
(
   input  logic                        clock,
   input  logic                        reset,
   input  pal_cmd_type                 cmd,
   output pal_status_type              status,
   input  logic                        csr_wen,
   input  logic [CSR_IDX_W-1:0]        csr_index,
   input  logic [ARC_W-1:0]            csr_wdata,
   input  logic [IDX_W-1:0]            point_index,
   input  logic signed [FIELD_W-1:0]   point_x,
   input  logic signed [FIELD_W-1:0]   point_y,
   input  logic [ARC_W-1:0]            point_arc,
   input  logic signed [FIELD_W-1:0]   query_arc,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic signed [FIELD_W-1:0]   pose_x,
   output logic signed [FIELD_W-1:0]   pose_y,
   output logic signed [HEAD_W-1:0]    heading
);

   localparam int AW    = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
   localparam int CNTW  = $clog2(MAX_POINTS + 1);
   localparam int TFRAC = ((61 - COORD_WIDTH) < 30) ? (61 - COORD_WIDTH) : 30;
   localparam int DW    = COORD_WIDTH + 1;
   localparam int PW    = DW + TFRAC + 1;
   localparam int PXW   = COORD_WIDTH + 2;
   localparam int TW    = TFRAC + 1;

   // config registers
   logic [PC_W-1:0]  pc_ff;
   logic             closed_ff;
   logic [ARC_W-1:0] total_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff     <= PC_W'(2);
         closed_ff <= 1'b0;
         total_ff  <= '0;
      end else if (csr_wen) begin
         unique case (pal_csr_type'(csr_index))
            CSR_POINT_COUNT:  pc_ff     <= csr_wdata[PC_W-1:0];
            CSR_CLOSED_TRACK: closed_ff <= csr_wdata[0];
            CSR_TOTAL_LENGTH: total_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // point table
   logic signed [COORD_WIDTH-1:0] mem_x [MAX_POINTS];
   logic signed [COORD_WIDTH-1:0] mem_y [MAX_POINTS];
   logic [ARC_W-1:0]              mem_a [MAX_POINTS];
   logic signed [COORD_WIDTH-1:0] rd_x_ff, rd_y_ff;
   logic [ARC_W-1:0]              rd_a_ff;
   logic [AW-1:0]                 rd_addr;
   logic                          wr_en;

   assign wr_en = (cmd.op == OP_WRITE) && ({22'b0, point_index} < 32'(MAX_POINTS));

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_x[AW'(point_index)] <= COORD_WIDTH'(point_x);
         mem_y[AW'(point_index)] <= COORD_WIDTH'(point_y);
         mem_a[AW'(point_index)] <= point_arc;
      end
      rd_x_ff <= mem_x[rd_addr];
      rd_y_ff <= mem_y[rd_addr];
      rd_a_ff <= mem_a[rd_addr];
   end

   // working registers
   logic signed [FIELD_W-1:0]     q_ff;
   logic [FIELD_W-1:0]            dvd_ff, rem_ff;
   logic [ARC_W-1:0]              sm_ff, seg_ff;
   logic [CNTW-1:0]               count_ff, lo_ff, hi_ff, mid_ff;
   logic [AW-1:0]                 j_ff;
   logic                          wrap_ff;
   logic signed [COORD_WIDTH-1:0] xi_ff, yi_ff;
   logic [ARC_W-1:0]              ai_ff;
   logic signed [DW-1:0]          dx_ff, dy_ff;
   logic [TW-1:0]                 t_ff;
   logic [PW-1:0]                 mulx_ff, muly_ff, accx_ff, accy_ff;
   logic signed [FIELD_W-1:0]     px_ff, py_ff;
   logic signed [CORDIC_W-1:0]    cx_ff, cy_ff;
   logic signed [ANG_W-1:0]       cz_ff;
   logic                          zero_ff;
   logic [CNT_W-1:0]              cnt_ff;
   logic                          rsp_valid_ff;
   logic signed [FIELD_W-1:0]     rsp_x_ff, rsp_y_ff;
   logic signed [HEAD_W-1:0]      rsp_h_ff;

   logic [31:0]              pc_ext;
   logic [CNTW-1:0]          count_in, mid, i_sel, j_sel;
   logic [FIELD_W-1:0]       mod_r, div_r;
   logic                     div_bit;
   logic signed [ARC_W+1:0]  seg_len, num;
   logic signed [DW-1:0]     dx_new, dy_new;
   logic [DW-1:0]            magx, magy;
   logic [PW-1:0]            offx_w, offy_w;
   logic signed [PXW-1:0]    offx, offy, px, py;
   logic signed [CORDIC_W-1:0] ax, ay, am, xs, ys, dxc, dyc;
   logic signed [ANG_W-1:0]  atan_s, zr;
   logic                     step_last;

   always_comb begin
      pc_ext = {21'b0, pc_ff};
      if (pc_ext < 32'd2) begin
         count_in = CNTW'(2);
      end else if (pc_ext > 32'(MAX_POINTS)) begin
         count_in = CNTW'(MAX_POINTS);
      end else begin
         count_in = CNTW'(pc_ext);
      end

      mid = lo_ff + ((hi_ff - lo_ff) >> 1);

      i_sel = (lo_ff == '0) ? '0 : lo_ff - CNTW'(1);
      j_sel = i_sel + CNTW'(1);
      if (j_sel >= count_ff) begin
         if (closed_ff) begin
            j_sel = '0;
         end else begin
            i_sel = count_ff - CNTW'(2);
            j_sel = count_ff - CNTW'(1);
         end
      end

      mod_r = {rem_ff[30:0], dvd_ff[31]};
      if (mod_r >= {1'b0, total_ff}) mod_r = mod_r - {1'b0, total_ff};

      div_r   = {rem_ff[30:0], 1'b0};
      div_bit = div_r >= {1'b0, seg_ff};
      if (div_bit) div_r = div_r - {1'b0, seg_ff};

      seg_len = wrap_ff ? ($signed({2'b0, total_ff}) - $signed({2'b0, ai_ff}))
                        : ($signed({2'b0, rd_a_ff}) - $signed({2'b0, ai_ff}));
      num     = $signed({2'b0, sm_ff}) - $signed({2'b0, ai_ff});
      dx_new  = DW'(rd_x_ff) - DW'(xi_ff);
      dy_new  = DW'(rd_y_ff) - DW'(yi_ff);
      magx    = dx_new[DW-1] ? DW'(-dx_new) : DW'(dx_new);
      magy    = dy_new[DW-1] ? DW'(-dy_new) : DW'(dy_new);

      // round half away from zero on the magnitude
      offx_w = (accx_ff + (PW'(1) << (TFRAC - 1))) >> TFRAC;
      offy_w = (accy_ff + (PW'(1) << (TFRAC - 1))) >> TFRAC;
      offx   = PXW'(offx_w);
      offy   = PXW'(offy_w);
      px     = dx_ff[DW-1] ? (PXW'(xi_ff) - offx) : (PXW'(xi_ff) + offx);
      py     = dy_ff[DW-1] ? (PXW'(yi_ff) - offy) : (PXW'(yi_ff) + offy);

      dxc = CORDIC_W'(dx_ff);
      dyc = CORDIC_W'(dy_ff);
      ax  = cx_ff[CORDIC_W-1] ? -cx_ff : cx_ff;
      ay  = cy_ff[CORDIC_W-1] ? -cy_ff : cy_ff;
      am  = (ax > ay) ? ax : ay;
      xs  = cx_ff >>> cnt_ff;
      ys  = cy_ff >>> cnt_ff;
      atan_s = $signed(atan_step(cnt_ff));
      zr  = cz_ff + ANG_W'(128);

      unique case (cmd.op)
         OP_MOD_STEP: step_last = cnt_ff == CNT_W'(31);
         OP_DIV_STEP: step_last = cnt_ff == CNT_W'(TFRAC - 1);
         OP_MUL_STEP: step_last = cnt_ff == CNT_W'(TFRAC);
         OP_ROT_STEP: step_last = cnt_ff == CNT_W'(ROT_STEPS - 1);
         default:     step_last = 1'b0;
      endcase
   end

   assign rd_addr = (cmd.op == OP_SRCH_ISSUE) ? mid[AW-1:0] :
                    (cmd.op == OP_RD_I)       ? i_sel[AW-1:0] :
                    (cmd.op == OP_RD_J)       ? j_ff : '0;

   always_comb begin
      status.mod_needed = closed_ff && (total_ff != '0);
      status.srch_more  = lo_ff < hi_ff;
      status.step_last  = step_last;
      status.t_direct   = (seg_len <= 0) || (num <= 0) || (num >= seg_len);
      status.norm_done  = zero_ff || (am >= (CORDIC_W'(1) <<< 40));
      status.out_free   = !rsp_valid_ff || rsp_ready;
   end

   always_ff @(posedge clock) begin
      unique case (cmd.op)
         OP_LOAD: begin
            q_ff     <= query_arc;
            dvd_ff   <= query_arc[31] ? FIELD_W'(-query_arc) : FIELD_W'(query_arc);
            rem_ff   <= '0;
            count_ff <= count_in;
            lo_ff    <= '0;
            hi_ff    <= count_in;
            cnt_ff   <= '0;
         end
         OP_MOD_STEP: begin
            rem_ff <= mod_r;
            dvd_ff <= {dvd_ff[30:0], 1'b0};
            cnt_ff <= step_last ? '0 : cnt_ff + CNT_W'(1);
         end
         OP_MOD_FIX: begin
            if (closed_ff) begin
               if (total_ff == '0) begin
                  sm_ff <= '0;
               end else if (q_ff[31] && (rem_ff != '0)) begin
                  sm_ff <= total_ff - rem_ff[ARC_W-1:0];
               end else begin
                  sm_ff <= rem_ff[ARC_W-1:0];
               end
            end else if (q_ff[31]) begin
               sm_ff <= '0;
            end else if (q_ff > $signed({1'b0, total_ff})) begin
               sm_ff <= total_ff;
            end else begin
               sm_ff <= q_ff[ARC_W-1:0];
            end
         end
         OP_SRCH_ISSUE: mid_ff <= mid;
         OP_SRCH_UPD: begin
            if (rd_a_ff <= sm_ff) lo_ff <= mid_ff + CNTW'(1);
            else hi_ff <= mid_ff;
         end
         OP_RD_I: begin
            j_ff    <= j_sel[AW-1:0];
            wrap_ff <= j_sel == '0;
         end
         OP_RD_J: begin
            xi_ff <= rd_x_ff;
            yi_ff <= rd_y_ff;
            ai_ff <= rd_a_ff;
         end
         OP_SETUP: begin
            dx_ff   <= dx_new;
            dy_ff   <= dy_new;
            mulx_ff <= PW'(magx);
            muly_ff <= PW'(magy);
            accx_ff <= '0;
            accy_ff <= '0;
            cnt_ff  <= '0;
            if ((seg_len <= 0) || (num <= 0)) begin
               t_ff <= '0;
            end else if (num >= seg_len) begin
               t_ff <= TW'(1) << TFRAC;
            end else begin
               t_ff   <= '0;
               rem_ff <= FIELD_W'(num);
               seg_ff <= seg_len[ARC_W-1:0];
            end
         end
         OP_DIV_STEP: begin
            rem_ff <= div_r;
            t_ff   <= {t_ff[TW-2:0], div_bit};
            cnt_ff <= step_last ? '0 : cnt_ff + CNT_W'(1);
         end
         OP_MUL_STEP: begin
            if (t_ff[0]) begin
               accx_ff <= accx_ff + mulx_ff;
               accy_ff <= accy_ff + muly_ff;
            end
            mulx_ff <= mulx_ff << 1;
            muly_ff <= muly_ff << 1;
            t_ff    <= t_ff >> 1;
            cnt_ff  <= step_last ? '0 : cnt_ff + CNT_W'(1);
         end
         OP_PRE: begin
            px_ff   <= FIELD_W'(px);
            py_ff   <= FIELD_W'(py);
            zero_ff <= (dx_ff == '0) && (dy_ff == '0);
            cnt_ff  <= '0;
            // fold into the right half plane
            if (dx_ff[DW-1]) begin
               if (!dy_ff[DW-1]) begin
                  cx_ff <= dyc;
                  cy_ff <= -dxc;
                  cz_ff <= ANG_W'(1) <<< 22;
               end else begin
                  cx_ff <= -dyc;
                  cy_ff <= dxc;
                  cz_ff <= -(ANG_W'(1) <<< 22);
               end
            end else begin
               cx_ff <= dxc;
               cy_ff <= dyc;
               cz_ff <= '0;
            end
         end
         OP_NORM_STEP: begin
            cx_ff <= cx_ff <<< 1;
            cy_ff <= cy_ff <<< 1;
         end
         OP_ROT_STEP: begin
            if (!cy_ff[CORDIC_W-1]) begin
               cx_ff <= cx_ff + ys;
               cy_ff <= cy_ff - xs;
               cz_ff <= cz_ff + atan_s;
            end else begin
               cx_ff <= cx_ff - ys;
               cy_ff <= cy_ff + xs;
               cz_ff <= cz_ff - atan_s;
            end
            cnt_ff <= step_last ? '0 : cnt_ff + CNT_W'(1);
         end
         OP_OUT: begin
            rsp_x_ff <= px_ff;
            rsp_y_ff <= py_ff;
            rsp_h_ff <= zero_ff ? '0 : zr[23:8];
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.op == OP_OUT) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign pose_x    = rsp_x_ff;
   assign pose_y    = rsp_y_ff;
   assign heading   = rsp_h_ff;

`ifndef SYNTHESIS
   a_sm_in_range: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == OP_SRCH_ISSUE) |-> (sm_ff <= total_ff))
      else $error("arc position beyond total length");
   a_search_bounds: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == OP_SRCH_UPD) |-> (lo_ff <= mid_ff && mid_ff < hi_ff && hi_ff <= count_ff))
      else $error("binary search bounds broken");
   a_t_range: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == OP_MUL_STEP && cnt_ff == '0) |-> (t_ff <= (TW'(1) << TFRAC)))
      else $error("interpolation fraction above one");
   a_out_free: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == OP_OUT) |-> (!rsp_valid_ff || rsp_ready))
      else $error("result register overwritten");
`endif

endmodule

[hw/rtl/polyline_arc_length_pose.sv]
// Polyline arc-length pose lookup.
// req_ channel: one word is either a point write (req_tuser = 0) that stores
// x, y and cumulative arc at point_index, or a pose query (req_tuser = 1).
// A point write returns nothing. A query returns one
// rsp_ word with interpolated x, y and the segment heading (32768 = pi).
// A query runs these steps in order on shared serial units: 32 modulo steps
// (closed track with nonzero total only), the binary search probes
// (about log2(point_count)+1 probes), the segment end point reads, TFRAC division steps
// (skipped when t saturates), TFRAC+1 multiply steps, up to 40 normalize
// shifts, 20 CORDIC steps and the output.
// One query is in flight at a time; the table has one write and one read port.
// The finished result sits in an output register, so a new word is taken
// while rsp_tvalid waits on rsp_tready; a stalled receiver only holds the
// next query in its last cycle. Reset clears control and config
// (point_count 2, open track, total 0); table contents are undefined until
// written. csr_ writes are allowed only while idle.
module polyline_arc_length_pose
   import pal_pkg::*;
#(
   parameter int MAX_POINTS  = MAX_POINTS_DEF,
   parameter int COORD_WIDTH = COORD_WIDTH_DEF
)
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // [9:0] point_index, [41:10] point_x, [73:42] point_y,
   // [104:74] point_arc, [136:105] query_arc, rest zero
   input  logic [REQ_DATA_W-1:0]  req_tdata,
   input  logic                   req_tuser,   // [0] operation
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // [31:0] pose_x, [63:32] pose_y, [79:64] heading
   output logic [RSP_DATA_W-1:0]  rsp_tdata,
   input  logic                   csr_wen,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [ARC_W-1:0]       csr_wdata
);

   pal_cmd_type    cmd;
   pal_status_type status;
   logic           req_fire;
   logic signed [FIELD_W-1:0] pose_x, pose_y;
   logic signed [HEAD_W-1:0]  heading;

   assign req_fire = req_tvalid && req_tready;

   pal_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_fire  (req_fire),
      .req_query (req_tuser),
      .status    (status),
      .cmd       (cmd),
      .req_ready (req_tready)
   );

   pal_dp #(
      .MAX_POINTS  (MAX_POINTS),
      .COORD_WIDTH (COORD_WIDTH)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .csr_wen     (csr_wen),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .point_index (req_tdata[9:0]),
      .point_x     ($signed(req_tdata[41:10])),
      .point_y     ($signed(req_tdata[73:42])),
      .point_arc   (req_tdata[104:74]),
      .query_arc   ($signed(req_tdata[136:105])),
      .rsp_valid   (rsp_tvalid),
      .rsp_ready   (rsp_tready),
      .pose_x      (pose_x),
      .pose_y      (pose_y),
      .heading     (heading)
   );

   assign rsp_tdata = {heading, pose_y, pose_x};

endmodule

[tb/sv/pal_checker.sv]
module pal_checker
   import pal_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   input  logic                   req_tready,
   input  logic [REQ_DATA_W-1:0]  req_tdata,
   input  logic                   req_tuser,
   input  logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   input  logic [RSP_DATA_W-1:0]  rsp_tdata,
   input  logic                   csr_wen,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [ARC_W-1:0]       csr_wdata,
   output int                     fail_count,
   output int                     pending
);

   localparam int TF = 29;   // t fraction bits at 32-bit coordinates

   // heading in the top bits, pose_x in the low bits, as on rsp_tdata
   typedef struct packed {
      logic [15:0] hd;
      logic [31:0] py;
      logic [31:0] px;
   } pose_t;

   longint pt_x [1024];
   longint pt_y [1024];
   longint pt_s [1024];
   int unsigned n_points;
   bit          loop_on;
   longint      track_len;
   pose_t       pose_q[$];

   const longint atan_tab[20] = '{2097152, 1238021, 654136, 332050, 166670, 83415,
      41718, 20860, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20, 10, 5};

   function automatic longint interp(longint a, longint b, longint t);
      longint d, mg, off;
      d = b - a;
      mg = (d < 0) ? -d : d;
      off = (t * mg + (longint'(1) << (TF - 1))) >>> TF;
      return (d < 0) ? a - off : a + off;
   endfunction

   function automatic logic [15:0] seg_heading(longint dx, longint dy);
      longint x, y, z, ax, ay, m, xs, ys;
      x = dx; y = dy; z = 0;
      if (dx == 0 && dy == 0) return 16'd0;
      if (dx < 0) begin
         if (dy >= 0) begin
            x = dy; y = -dx; z = 4194304;
         end else begin
            x = -dy; y = dx; z = -4194304;
         end
      end
      ax = (x < 0) ? -x : x;
      ay = (y < 0) ? -y : y;
      m = (ax > ay) ? ax : ay;
      while (m < (longint'(1) << 40)) begin
         x = x * 2; y = y * 2; m = m * 2;
      end
      for (int k = 0; k < 20; k++) begin
         xs = x >>> k; ys = y >>> k;
         if (y >= 0) begin
            x = x + ys; y = y - xs; z = z + atan_tab[k];
         end else begin
            x = x - ys; y = y + xs; z = z - atan_tab[k];
         end
      end
      z = (z + 128) >>> 8;
      return z[15:0];
   endfunction

   function automatic pose_t locate(longint q);
      longint sm, s0, len, num, t, dx, dy;
      int unsigned lo, hi, mid, i, j, cnt;
      pose_t r;
      cnt = (n_points < 2) ? 2 : ((n_points > 1024) ? 1024 : n_points);
      if (loop_on) begin
         if (track_len == 0) sm = 0;
         else begin
            sm = q % track_len;
            if (sm < 0) sm += track_len;
         end
      end else sm = (q < 0) ? 0 : ((q > track_len) ? track_len : q);
      lo = 0; hi = cnt;
      while (lo < hi) begin
         mid = lo + (hi - lo) / 2;
         if (pt_s[mid] <= sm) lo = mid + 1;
         else hi = mid;
      end
      i = (lo == 0) ? 0 : lo - 1;
      if (i + 1 < cnt) j = i + 1;
      else if (loop_on) j = 0;
      else begin
         i = cnt - 2; j = cnt - 1;
      end
      s0 = pt_s[i];
      len = (j == 0) ? (track_len - s0) : (pt_s[j] - s0);
      num = sm - s0;
      if (len <= 0 || num <= 0) t = 0;
      else if (num >= len) t = longint'(1) << TF;
      else t = (num << TF) / len;
      r.px = interp(pt_x[i], pt_x[j], t);
      r.py = interp(pt_y[i], pt_y[j], t);
      dx = pt_x[j] - pt_x[i];
      dy = pt_y[j] - pt_y[i];
      r.hd = seg_heading(dx, dy);
      return r;
   endfunction

   task automatic report(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch %s: got %h want %h", what, got, want);
      fail_count++;
   endtask

   always @(posedge clock) begin
      pose_t got, want;
      if (reset) begin
         fail_count = 0;
         pending = 0;
         n_points = 2; loop_on = 0; track_len = 0;
         for (int k = 0; k < 1024; k++) begin
            pt_x[k] = 0; pt_y[k] = 0; pt_s[k] = 0;
         end
      end else begin
         if (csr_wen) begin
            case (pal_csr_type'(csr_index))
               CSR_POINT_COUNT:  n_points = csr_wdata[10:0];
               CSR_CLOSED_TRACK: loop_on = csr_wdata[0];
               CSR_TOTAL_LENGTH: track_len = longint'(csr_wdata);
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata;
            if (pose_q.size() == 0) begin
               report("unexpected pose_x", got.px, 32'd0);
            end else begin
               want = pose_q.pop_front();
               if (got.px != want.px) report("pose_x", got.px, want.px);
               if (got.py != want.py) report("pose_y", got.py, want.py);
               if (got.hd != want.hd)
                  report("heading", {16'd0, got.hd}, {16'd0, want.hd});
            end
         end
         if (req_tvalid && req_tready) begin
            if (req_tuser == 1'b0) begin
               pt_x[req_tdata[9:0]] = longint'(signed'(req_tdata[41:10]));
               pt_y[req_tdata[9:0]] = longint'(signed'(req_tdata[73:42]));
               pt_s[req_tdata[9:0]] = longint'(req_tdata[104:74]);
            end else
               pose_q.push_back(locate(longint'(signed'(req_tdata[136:105]))));
         end
         pending = pose_q.size();
      end
   end

endmodule

[tb/sv/tb_polyline_arc_length_pose.sv]
module tb_polyline_arc_length_pose;
   import pal_pkg::*;

   localparam int QUIET_LIMIT = 20000;   // cycles with no word moving

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;   // index, x, y, arc, query (low first)
   logic                  req_tuser;   // [0] operation
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;   // pose_x, pose_y, heading (low first)
   logic                  csr_wen;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [ARC_W-1:0]      csr_wdata;
   int                    fail_count;
   int                    pending;

   // receiver control: count of long hold-off requests
   int                    hold_req;
   int                    quiet;

   // host copy of the current track, so queries only touch written points
   int                    pts;
   bit                    loop_now;
   longint                len_now;

   polyline_arc_length_pose DUT (.*);

   pal_checker u_chk (.*);

   always begin
      clock = 1'b0; #1;
      clock = 1'b1; #1;
   end

   // watchdog: nothing accepted for too long ends the run
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || reset)
         quiet <= 0;
      else
         quiet <= quiet + 1;
      if (quiet >= QUIET_LIMIT) begin
         $display("tb_polyline_arc_length_pose: errors");
         $finish;
      end
   end

   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 93) return $urandom_range(1, 4);
      return $urandom_range(20, 300);
   endfunction

   // receiver: random stalls, plus a long hold-off on request
   initial begin
      int g;
      int hold_done;
      hold_done = 0;
      rsp_tready = 1'b0;
      @(negedge clock);
      forever begin
         if (hold_req != hold_done) begin
            rsp_tready <= 1'b0;
            repeat (3000) @(negedge clock);
            hold_done = hold_req;
         end
         g = gap_len();
         if (g == 0) begin
            rsp_tready <= 1'b1;
            @(negedge clock);
         end else begin
            rsp_tready <= 1'b0;
            repeat (g) @(negedge clock);
         end
      end
   end

   // leaves req_tvalid high after the accept; the next word or a drain follows
   task automatic send_word(bit op, logic [9:0] idx, logic [31:0] x, logic [31:0] y,
                            logic [30:0] arc, logic [31:0] q);
      int g;
      g = gap_len();
      if (g > 0) begin
         req_tvalid <= 1'b0;
         repeat (g) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {7'd0, q, arc, y, x, idx};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (300) @(negedge clock);
   endtask

   task automatic csr_write(pal_csr_type r, logic [30:0] v);
      csr_wen   <= 1'b1;
      csr_index <= r;
      csr_wdata <= v;
      @(negedge clock);
      csr_wen   <= 1'b0;
      @(negedge clock);
   endtask

   // builds a track of n points with random geometry; arc strictly or loosely rising
   task automatic load_track(int n, bit closed, int step_max, bit extreme);
      longint s;
      logic [31:0] x, y;
      s = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 1000);
      for (int k = 0; k < n; k++) begin
         if (extreme) begin
            x = $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_ffff;
            y = $urandom();
         end else if ($urandom_range(0, 9) == 0 && k > 0) begin
            x = 0; y = 0;   // may repeat a point: degenerate segment
         end else begin
            x = $urandom(); y = $urandom();
         end
         if (k > 0 && $urandom_range(0, 9) == 0) s = s;   // zero-length segment
         else if (k > 0) s = s + $urandom_range(1, step_max);
         if (s > 64'h7fff_ffff) s = 64'h7fff_ffff;
         send_word(1'b0, k[9:0], x, y, s[30:0], $urandom());
      end
      drain();
      pts = n;
      loop_now = closed;
      len_now = s + ($urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, step_max));
      if (len_now > 64'h7fff_ffff) len_now = 64'h7fff_ffff;
      if ($urandom_range(0, 7) == 0) len_now = 0;
      csr_write(CSR_POINT_COUNT, 31'(n));
      csr_write(CSR_CLOSED_TRACK, 31'(closed));
      csr_write(CSR_TOTAL_LENGTH, len_now[30:0]);
   endtask

   task automatic query_burst(int n);
      logic [31:0] q;
      int r;
      for (int k = 0; k < n; k++) begin
         r = $urandom_range(0, 9);
         if (r < 6) q = $urandom_range(0, (len_now > 0) ? len_now[30:0] : 1);
         else if (r == 6) q = $urandom();
         else if (r == 7) q = 32'h8000_0000;
         else if (r == 8) q = 32'h7fff_ffff;
         else q = -$urandom_range(1, 5000);
         send_word(1'b1, 10'($urandom()), $urandom(), $urandom(), 31'($urandom()), q);
      end
   endtask

   initial begin
      int rounds;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tuser  = 1'b0;
      req_tdata  = '0;
      csr_wen    = 1'b0;
      csr_index  = CSR_POINT_COUNT;
      csr_wdata  = '0;
      hold_req   = 0;
      repeat (10) @(negedge clock);
      reset = 1'b0;

      // directed: two-point defaults, extremes of coordinates and queries
      load_track(2, 0, 65536, 1);
      csr_write(CSR_TOTAL_LENGTH, 31'h7fff_ffff);
      len_now = 64'h7fff_ffff;
      send_word(1'b1, '0, '0, '0, '0, 32'h8000_0000);
      send_word(1'b1, '0, '0, '0, '0, 32'h7fff_ffff);
      send_word(1'b1, '0, '0, '0, '0, 32'h0000_0000);
      drain();
      // heading of exactly pi, vertical and degenerate segments
      send_word(1'b0, 10'd0, 32'h0001_0000, '0, '0, '0);
      send_word(1'b0, 10'd1, 32'hffff_0000, '0, 31'h0001_0000, '0);
      send_word(1'b0, 10'd2, 32'hffff_0000, 32'h0001_0000, 31'h0002_0000, '0);
      send_word(1'b0, 10'd3, 32'hffff_0000, 32'h0001_0000, 31'h0002_0000, '0);
      drain();
      csr_write(CSR_POINT_COUNT, 31'd4);
      csr_write(CSR_CLOSED_TRACK, 31'd1);
      csr_write(CSR_TOTAL_LENGTH, 31'h0001_8000);   // wrap segment below last arc
      pts = 4; loop_now = 1; len_now = 32'h0001_8000;
      send_word(1'b1, '0, '0, '0, '0, 32'h0000_8000);
      send_word(1'b1, '0, '0, '0, '0, 32'h0001_4000);
      send_word(1'b1, '0, '0, '0, '0, 32'hffff_0000);
      drain();
      csr_write(CSR_TOTAL_LENGTH, 31'd0);           // closed with zero total
      send_word(1'b1, '0, '0, '0, '0, 32'h1234_5678);
      drain();
      csr_write(CSR_CLOSED_TRACK, 31'd0);
      send_word(1'b1, '0, '0, '0, '0, 32'h0001_0000);
      drain();

      // random phases: small tracks mostly, a full-size track in at most one round
      rounds = 0;
      while (rounds < 34) begin
         case ($urandom_range(0, 4))
            0: load_track(2, $urandom_range(0, 1), 1 << 20, 0);
            1: load_track($urandom_range(3, 8), $urandom_range(0, 1), 1 << 22, 0);
            2: load_track($urandom_range(9, 40), $urandom_range(0, 1), 1 << 16, 0);
            3: load_track((rounds == 7) ? 1024 : $urandom_range(2, 16),
                          $urandom_range(0, 1), 1 << 21, 0);
            default: load_track($urandom_range(2, 6), $urandom_range(0, 1), 1 << 30, 1);
         endcase
         if (rounds == 3) hold_req++;     // receiver stalls while queries pile up
         query_burst(28);
         if (rounds == 10) drain();       // sender waits for every result
         rounds++;
      end

      drain();
      if (fail_count == 0)
         $display("tb_polyline_arc_length_pose: clean");
      else
         $display("tb_polyline_arc_length_pose: errors");
      $finish;
   end

endmodule

[polyline_arc_length_pose.f]
hw/rtl/pal_pkg.sv
hw/rtl/pal_ctrl.sv
hw/rtl/pal_dp.sv
hw/rtl/polyline_arc_length_pose.sv
tb/sv/pal_checker.sv
tb/sv/tb_polyline_arc_length_pose.sv
